FILE: design/eyr_pkg.sv
// ----------------------------------------------------------------------------
// Euler rotation package
// Shared widths and types for the Y-X-Z Euler vector rotation block.
// ----------------------------------------------------------------------------
package eyr_pkg;
   localparam int ANGLE_BITS     = 16;
   localparam int VECTOR_BITS    = 32;
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
   localparam int QUARTER_BITS   = ANGLE_BITS - 2;
   localparam int SINE_LATENCY   = 15;

   typedef logic signed [VECTOR_BITS-1:0] vec_type;
   typedef logic [ANGLE_BITS-1:0]         angle_type;
   typedef logic signed [TRIG_BITS-1:0]   trig_type;

   typedef struct packed {
      vec_type   vx;
      vec_type   vy;
      vec_type   vz;
      angle_type ax;
      angle_type ay;
      angle_type az;
   } item_type;

   // Rounded product of two trig values, half up.
   function automatic trig_type tmul(input trig_type a, input trig_type b);
      logic signed [2*TRIG_BITS-1:0] p;
      p = a * b + (2*TRIG_BITS)'(1 <<< (TRIG_FRAC_BITS - 1));
      return trig_type'(p >>> TRIG_FRAC_BITS);
   endfunction
endpackage

FILE: design/euler_yxz_vector_rotation.sv
// ----------------------------------------------------------------------------
// Euler Y-X-Z vector rotation
// Rotates a Q16.16 vector by R = Ry*Rx*Rz built from three binary angles.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// req      in         vec_x, vec_y, vec_z, pitch, yaw, roll
// rsp      out        rot_x, rot_y, rot_z, saturated
//
// One word per cycle unless rsp stalls; an accepted word passes through the
// four-word queue and then the back end, in which the fifteen-stage sine
// pipeline is the longest part.
// Reset clears the queue pointers and the pipeline valid bits.
// A stalled result freezes the whole back end; the queue absorbs input.
module euler_yxz_vector_rotation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eyr_pkg::vec_type req_vec_x,
   input  eyr_pkg::vec_type req_vec_y,
   input  eyr_pkg::vec_type req_vec_z,
   input  eyr_pkg::angle_type req_pitch,
   input  eyr_pkg::angle_type req_yaw,
   input  eyr_pkg::angle_type req_roll,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eyr_pkg::vec_type rsp_rot_x,
   output eyr_pkg::vec_type rsp_rot_y,
   output eyr_pkg::vec_type rsp_rot_z,
   output logic             rsp_saturated
);
   import eyr_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item = '{vx: req_vec_x, vy: req_vec_y, vz: req_vec_z,
                      ax: req_pitch, ay: req_yaw, az: req_roll};

   eyr_front u_front (.clock, .reset, .req_valid, .req_ready, .req_item(in_item),
                      .q_valid, .q_ready, .q_item);

   eyr_back u_back (.clock, .reset, .q_valid, .q_ready, .q_item, .rsp_valid, .rsp_ready,
                    .rsp_rot_x, .rsp_rot_y, .rsp_rot_z, .rsp_saturated);
endmodule

FILE: design/eyr_sine.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine pipeline
// Fifteen-stage Horner evaluation of sine and cosine of a binary angle.
// ----------------------------------------------------------------------------
module eyr_sine (
   input  logic               clock,
   input  logic               en,
   input  eyr_pkg::angle_type angle,
   output eyr_pkg::trig_type  sin_out,
   output eyr_pkg::trig_type  cos_out
);
   import eyr_pkg::*;

   localparam int NT    = 2;
   localparam int STEPS = 6;
   localparam int D     = SINE_LATENCY - 1;
   localparam logic [63:0] HALF_PI = 64'd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] RECIP_39 = 32'(((64'd1 << 36) + 64'd38) / 64'd39);
   localparam logic [31:0] RECIP_55 = 32'(((64'd1 << 37) + 64'd54) / 64'd55);
   localparam logic [31:0] RECIP_9  = 32'(((64'd1 << 33) + 64'd8) / 64'd9);
   localparam logic [31:0] RECIP_21 = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
   localparam logic [31:0] RECIP_5  = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
   localparam logic [31:0] RECIP_3  = 32'(((64'd1 << 33) + 64'd2) / 64'd3);

   typedef struct packed {
      logic [1:0]  quad;
      logic        zero;
      logic        full;
      logic [30:0] x;
      logic [31:0] x2;
      logic [31:0] n;
      logic [30:0] t;
   } sine_stage_type;

   logic [1:0]     quad_in [NT];
   sine_stage_type st_ff   [NT][D];
   trig_type       res_ff  [NT];

   // Floor division by 156, 110, 72, 42, 20 and 6: a shift for the power of
   // two, then a multiply by the reciprocal of the odd factor.
   function automatic logic [31:0] div_step(input logic [31:0] n, input int j);
      logic [63:0] p;
      case (j)
         0:       p = (64'(n >> 2) * 64'(RECIP_39)) >> 36;
         1:       p = (64'(n >> 1) * 64'(RECIP_55)) >> 37;
         2:       p = (64'(n >> 3) * 64'(RECIP_9)) >> 33;
         3:       p = (64'(n >> 1) * 64'(RECIP_21)) >> 36;
         4:       p = (64'(n >> 2) * 64'(RECIP_5)) >> 33;
         default: p = (64'(n >> 1) * 64'(RECIP_3)) >> 33;
      endcase
      return 32'(p);
   endfunction

   always_comb begin
      quad_in[0] = angle[ANGLE_BITS-1 -: 2];
      quad_in[1] = 2'(angle[ANGLE_BITS-1 -: 2] + 2'd1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NT; i++) begin
            logic [QUARTER_BITS:0] k;
            logic [63:0]           xm;
            logic [61:0]           sq;
            logic [61:0]           sp;
            logic [30:0]           s;
            sine_stage_type        head, na, nb, last;
            k = {1'b0, angle[QUARTER_BITS-1:0]};
            if (quad_in[i][0]) k = (QUARTER_BITS+1)'(1 << QUARTER_BITS) - k;
            xm = 64'(k) * HALF_PI + 64'(1 << (QUARTER_BITS - 1));
            head      = '0;
            head.quad = quad_in[i];
            head.zero = (k == '0);
            head.full = k[QUARTER_BITS];
            head.x    = 31'(xm >> QUARTER_BITS);
            st_ff[i][0] <= head;
            na = st_ff[i][0];
            sq = 62'(na.x) * 62'(na.x) + 62'(1 << 29);
            na.x2 = 32'(sq >> 30);
            na.t  = ONE_Q30;
            st_ff[i][1] <= na;
            for (int j = 0; j < STEPS; j++) begin
               na = st_ff[i][2*j+1];
               na.n = 32'((64'(na.x2) * 64'(na.t)) >> 30);
               st_ff[i][2*j+2] <= na;
               nb = st_ff[i][2*j+2];
               nb.t = ONE_Q30 - 31'(div_step(nb.n, j));
               st_ff[i][2*j+3] <= nb;
            end
            last = st_ff[i][D-1];
            sp = 62'(last.x) * 62'(last.t);
            s  = 31'(((sp >> 30) + 62'(1 << (30 - TRIG_FRAC_BITS - 1)))
                     >> (30 - TRIG_FRAC_BITS));
            if (last.zero) s = '0;
            else if (last.full || s > 31'(1 << TRIG_FRAC_BITS)) s = 31'(1 << TRIG_FRAC_BITS);
            res_ff[i] <= last.quad[1] ? -trig_type'(s) : trig_type'(s);
         end
      end
   end

   assign sin_out = res_ff[0];
   assign cos_out = res_ff[1];
endmodule

FILE: design/eyr_front.sv
// ----------------------------------------------------------------------------
// Rotation front end
// Accepts items and writes them into a short queue for the datapath.
// ----------------------------------------------------------------------------
module eyr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eyr_pkg::item_type req_item,
   output logic              q_valid,
   input  logic              q_ready,
   output eyr_pkg::item_type q_item
);
   import eyr_pkg::*;

   item_type   mem_ff [4];
   logic [2:0] wp_ff, rp_ff;
   logic       push, pop;

   assign req_ready = (wp_ff - rp_ff) != 3'd4;
   assign q_valid   = wp_ff != rp_ff;
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign q_item    = mem_ff[rp_ff[1:0]];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff[1:0]] <= req_item;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 3'd1;
         if (pop)  rp_ff <= rp_ff + 3'd1;
      end
   end
endmodule

FILE: design/eyr_back.sv
// ----------------------------------------------------------------------------
// Rotation back end
// Trig, matrix and dot-product pipeline with a stalling output register.
// ----------------------------------------------------------------------------
module eyr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  eyr_pkg::item_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eyr_pkg::vec_type  rsp_rot_x,
   output eyr_pkg::vec_type  rsp_rot_y,
   output eyr_pkg::vec_type  rsp_rot_z,
   output logic              rsp_saturated
);
   import eyr_pkg::*;

   localparam int NS = SINE_LATENCY + 5;
   localparam int VD = SINE_LATENCY + 2;
   localparam int PB = TRIG_BITS + VECTOR_BITS;
   localparam int SB = PB + 2;

   logic     v_ff [NS];
   vec_type  v0_ff [VD], v1_ff [VD], v2_ff [VD];
   trig_type sx, cx, sy, cy, sz, cz;
   trig_type sxsz_ff, sxcz_ff, sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;
   trig_type m_ff [9];
   logic signed [PB-1:0] ph_ff [9], pl_ff [9];
   logic signed [SB-1:0] sh_ff [3], sl_ff [3];
   logic signed [SB:0]   r_ff [3];
   logic en;

   assign en      = !rsp_valid || rsp_ready;
   assign q_ready = en;

   eyr_sine u_sx (.clock, .en, .angle(q_item.ax), .sin_out(sx), .cos_out(cx));
   eyr_sine u_sy (.clock, .en, .angle(q_item.ay), .sin_out(sy), .cos_out(cy));
   eyr_sine u_sz (.clock, .en, .angle(q_item.az), .sin_out(sz), .cos_out(cz));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= q_valid;
         for (int i = 1; i < NS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0_ff[0] <= q_item.vx; v1_ff[0] <= q_item.vy; v2_ff[0] <= q_item.vz;
         for (int i = 1; i < VD; i++) begin
            v0_ff[i] <= v0_ff[i-1]; v1_ff[i] <= v1_ff[i-1]; v2_ff[i] <= v2_ff[i-1];
         end
         // Pair products of the x sine with the z sine and cosine.
         sxsz_ff <= tmul(sx, sz); sxcz_ff <= tmul(sx, cz);
         sx_ff <= sx; cx_ff <= cx; sy_ff <= sy; cy_ff <= cy; sz_ff <= sz; cz_ff <= cz;
         // Matrix entries.
         m_ff[0] <= tmul(cy_ff, cz_ff) - tmul(sy_ff, sxsz_ff);
         m_ff[1] <= tmul(cy_ff, sz_ff) + tmul(sy_ff, sxcz_ff);
         m_ff[2] <= -tmul(sy_ff, cx_ff);
         m_ff[3] <= -tmul(cx_ff, sz_ff);
         m_ff[4] <= tmul(cx_ff, cz_ff);
         m_ff[5] <= sx_ff;
         m_ff[6] <= tmul(sy_ff, cz_ff) + tmul(cy_ff, sxsz_ff);
         m_ff[7] <= tmul(sy_ff, sz_ff) - tmul(cy_ff, sxcz_ff);
         m_ff[8] <= tmul(cy_ff, cx_ff);
         // Split products, high and low halves of each component.
         for (int i = 0; i < 9; i++) begin
            vec_type v;
            v = (i % 3 == 0) ? v0_ff[VD-1] : (i % 3 == 1) ? v1_ff[VD-1] : v2_ff[VD-1];
            ph_ff[i] <= PB'(m_ff[i]) * PB'(v >>> TRIG_FRAC_BITS);
            pl_ff[i] <= PB'(m_ff[i]) * PB'($signed({1'b0, v[TRIG_FRAC_BITS-1:0]}));
         end
         // Row sums.
         for (int r = 0; r < 3; r++) begin
            sh_ff[r] <= SB'(ph_ff[3*r]) + SB'(ph_ff[3*r+1]) + SB'(ph_ff[3*r+2]);
            sl_ff[r] <= SB'(pl_ff[3*r]) + SB'(pl_ff[3*r+1]) + SB'(pl_ff[3*r+2])
                        + SB'(1 << (TRIG_FRAC_BITS - 1));
         end
         // Combine into the output register; saturation follows on its output.
         for (int r = 0; r < 3; r++)
            r_ff[r] <= (SB+1)'(sh_ff[r]) + (SB+1)'(sl_ff[r] >>> TRIG_FRAC_BITS);
      end
   end

   function automatic logic ovf(input logic signed [SB:0] r);
      return (r != (SB+1)'($signed(vec_type'(r))));
   endfunction

   function automatic vec_type clip(input logic signed [SB:0] r);
      if (!ovf(r)) return vec_type'(r);
      return r[SB] ? {1'b1, {(VECTOR_BITS-1){1'b0}}} : {1'b0, {(VECTOR_BITS-1){1'b1}}};
   endfunction

   assign rsp_valid     = v_ff[NS-1];
   assign rsp_rot_x     = clip(r_ff[0]);
   assign rsp_rot_y     = clip(r_ff[1]);
   assign rsp_rot_z     = clip(r_ff[2]);
   assign rsp_saturated = ovf(r_ff[0]) || ovf(r_ff[1]) || ovf(r_ff[2]);
endmodule

FILE: design/eyr_checker.sv
// ----------------------------------------------------------------------------
// Rotation port checker
// Port-level assertions bound to the rotation block.
// ----------------------------------------------------------------------------
module eyr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input eyr_pkg::vec_type rsp_rot_x,
   input logic             rsp_saturated
);
   import eyr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rot_x) && $stable(rsp_saturated))
      else $error("Stalled result word changed.");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word straight after reset.");
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("Input not ready after reset.");
endmodule

bind euler_yxz_vector_rotation eyr_checker u_eyr_checker (.clock, .reset,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_rot_x, .rsp_saturated);
